// ----- rtl/rgbnv_pkg.sv -----
// Shared types, constants and helpers of the RGB565 to NV12 converter.
`default_nettype none
package rgbnv_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int MAX_STRIDE    = 8192;

    localparam int DIM_W    = $clog2(MAX_DIMENSION) + 1;
    localparam int CNT_W    = $clog2(MAX_DIMENSION);
    localparam int STRIDE_W = $clog2(MAX_STRIDE) + 1;
    localparam int OFS_W    = 25;
    localparam int PIX_W    = 16;
    localparam int COL_W    = 8;
    localparam int ACC_W    = 25;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = STRIDE_W;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    localparam logic [DIM_W-1:0]    RST_WIDTH  = DIM_W'(1280);
    localparam logic [DIM_W-1:0]    RST_HEIGHT = DIM_W'(720);
    localparam logic [STRIDE_W-1:0] RST_STRIDE = STRIDE_W'(1280);

    // BT.601 studio range, Q16
    localparam logic [ACC_W-1:0] Y_R = ACC_W'(16843);
    localparam logic [ACC_W-1:0] Y_G = ACC_W'(33030);
    localparam logic [ACC_W-1:0] Y_B = ACC_W'(6423);
    localparam logic [ACC_W-1:0] U_R = ACC_W'(9699);
    localparam logic [ACC_W-1:0] U_G = ACC_W'(19071);
    localparam logic [ACC_W-1:0] U_B = ACC_W'(28770);
    localparam logic [ACC_W-1:0] V_R = ACC_W'(28770);
    localparam logic [ACC_W-1:0] V_G = ACC_W'(24117);
    localparam logic [ACC_W-1:0] V_B = ACC_W'(4653);
    localparam logic [ACC_W-1:0] Y_BIAS = ACC_W'(16 * 65536);
    localparam logic [ACC_W-1:0] C_BIAS = ACC_W'(128 * 65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = CFG_IDX_W'(0),
        CFG_FRAME_HEIGHT  = CFG_IDX_W'(1),
        CFG_SOURCE_STRIDE = CFG_IDX_W'(2),
        CFG_LUMA_STRIDE   = CFG_IDX_W'(3)
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [STRIDE_W-1:0] luma_stride;
        logic                stride_error;
    } cfg_t;

    typedef struct packed {
        logic [OFS_W-1:0] luma_offset;
        logic [OFS_W-1:0] chroma_offset;
        logic             chroma;
        logic             last;
        logic             stride_error;
    } pos_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIMENSION))
            r = DIM_W'(MAX_DIMENSION);
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rgb565_to_nv12_converter_unit.sv -----
// Top level of the RGB565 to NV12 converter: handshake, pipeline and result register.
// Data path: an input transfer loads the input register; the result register loads from it
// once the output is free, and the output transfer is taken from the result register.
// Throughput: one pixel per cycle while the output is not stalled; the conversion stage is combinational.
// Stalls propagate back through a two-entry pipeline (input and result register).
// Reset: counters and offsets clear to frame start, registers return to 1280x720.
`default_nettype none
module rgb565_to_nv12_converter_unit
    import rgbnv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] pixel
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] luma, [32:8] luma_offset, [40:33] chroma_u, [48:41] chroma_v,
    // [73:49] chroma_offset, [79:74] zero
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic      [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] chroma_valid, [1] stride_error
    output logic                        m_axis_tlast,   // last_of_frame
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    pos_t pos;

    logic             in_fire;
    logic             out_load;
    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_pixel_reg;
    pos_t             s1_pos_reg;
    logic             m_valid_reg, m_valid_next;
    logic [COL_W-1:0] csc_y, csc_u, csc_v;
    logic             wr_luma, wr_chroma;

    logic [COL_W-1:0] luma_reg;
    logic [OFS_W-1:0] luma_ofs_reg;
    logic [COL_W-1:0] u_reg, v_reg;
    logic [OFS_W-1:0] chroma_ofs_reg;
    logic             chroma_valid_reg;
    logic             err_reg;
    logic             last_reg;

    assign cfg_ready = 1'b1;

    rgbnv_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rgbnv_raster u_raster (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .cfg     (cfg),
        .pos     (pos)
    );

    rgbnv_csc u_csc (
        .pixel (s1_pixel_reg),
        .y     (csc_y),
        .u     (csc_u),
        .v     (csc_v)
    );

    always_comb
    begin
        out_load      = s1_valid_reg && (!m_valid_reg || m_axis_tready);
        s_axis_tready = !s1_valid_reg || out_load;
        in_fire       = s_axis_tvalid && s_axis_tready;

        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;

        wr_luma   = !s1_pos_reg.stride_error;
        wr_chroma = wr_luma && s1_pos_reg.chroma;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= s_axis_tdata[PIX_W-1:0];
            s1_pos_reg   <= pos;
        end
        if (out_load)
        begin
            luma_reg         <= wr_luma ? csc_y : '0;
            luma_ofs_reg     <= wr_luma ? s1_pos_reg.luma_offset : '0;
            chroma_valid_reg <= wr_chroma;
            u_reg            <= wr_chroma ? csc_u : '0;
            v_reg            <= wr_chroma ? csc_v : '0;
            chroma_ofs_reg   <= wr_chroma ? s1_pos_reg.chroma_offset : '0;
            err_reg          <= s1_pos_reg.stride_error;
            last_reg         <= s1_pos_reg.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, chroma_ofs_reg, v_reg, u_reg, luma_ofs_reg, luma_reg};
    assign m_axis_tuser  = {err_reg, chroma_valid_reg};
    assign m_axis_tlast  = last_reg;

    a_err_no_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("chroma flagged on a stride error result");

    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("write data present on a stride error result");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_pixel_reg))
        else $error("pipeline stage lost a pixel while stalled");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && m_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted with a full pipeline");

endmodule
`default_nettype wire

// ----- rtl/rgbnv_cfg_regs.sv -----
// Configuration registers with frame size clamping and stride check.
`default_nettype none
module rgbnv_cfg_regs
    import rgbnv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [STRIDE_W-1:0] src_stride_reg;
    logic [STRIDE_W-1:0] luma_stride_reg;
    logic [DIM_W-1:0]    width_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= RST_WIDTH;
            height_reg      <= RST_HEIGHT;
            src_stride_reg  <= RST_STRIDE;
            luma_stride_reg <= RST_STRIDE;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_FRAME_WIDTH:   width_reg       <= wr_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:  height_reg      <= wr_data[DIM_W-1:0];
                CFG_SOURCE_STRIDE: src_stride_reg  <= wr_data[STRIDE_W-1:0];
                CFG_LUMA_STRIDE:   luma_stride_reg <= wr_data[STRIDE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        width_eff        = clamp_dim(width_reg);
        cfg.width        = width_eff;
        cfg.height       = clamp_dim(height_reg);
        cfg.luma_stride  = luma_stride_reg;
        cfg.stride_error = (STRIDE_W'(width_eff) > src_stride_reg) ||
                           (STRIDE_W'(width_eff) > luma_stride_reg);
    end

endmodule
`default_nettype wire

// ----- rtl/rgbnv_raster.sv -----
// Raster position counters and plane offset generation.
`default_nettype none
module rgbnv_raster
    import rgbnv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  cfg_t      cfg,
    output pos_t      pos
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [OFS_W-1:0] luma_base_reg, luma_base_next;
    logic [OFS_W-1:0] chroma_base_reg, chroma_base_next;
    logic             row_end;
    logic             last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            luma_base_reg   <= '0;
            chroma_base_reg <= '0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            luma_base_reg   <= luma_base_next;
            chroma_base_reg <= chroma_base_next;
        end
    end

    always_comb
    begin
        row_end = ({1'b0, col_reg} + DIM_W'(1)) >= cfg.width;
        last    = row_end && (({1'b0, row_reg} + DIM_W'(1)) >= cfg.height);

        pos.luma_offset   = luma_base_reg + OFS_W'(col_reg);
        pos.chroma_offset = chroma_base_reg + OFS_W'(col_reg);
        pos.chroma        = !row_reg[0] && !col_reg[0];
        pos.last          = last;
        pos.stride_error  = cfg.stride_error;

        col_next         = col_reg;
        row_next         = row_reg;
        luma_base_next   = luma_base_reg;
        chroma_base_next = chroma_base_reg;
        if (advance)
        begin
            if (last)
            begin
                col_next         = '0;
                row_next         = '0;
                luma_base_next   = '0;
                chroma_base_next = '0;
            end
            else if (row_end)
            begin
                col_next       = '0;
                row_next       = row_reg + CNT_W'(1);
                luma_base_next = luma_base_reg + OFS_W'(cfg.luma_stride);
                if (!row_reg[0])
                    chroma_base_next = chroma_base_reg + OFS_W'(cfg.luma_stride);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rgbnv_csc.sv -----
// RGB565 expansion and BT.601 Y/U/V color space conversion.
`default_nettype none
module rgbnv_csc
    import rgbnv_pkg::*;
(
    input  wire logic [PIX_W-1:0] pixel,
    output logic      [COL_W-1:0] y,
    output logic      [COL_W-1:0] u,
    output logic      [COL_W-1:0] v
);

    logic [ACC_W-1:0] r;
    logic [ACC_W-1:0] g;
    logic [ACC_W-1:0] b;
    logic [ACC_W-1:0] y_sum;
    logic [ACC_W-1:0] u_sum;
    logic [ACC_W-1:0] v_sum;

    always_comb
    begin
        r = ACC_W'({pixel[15:11], 3'b000});
        g = ACC_W'({pixel[10:5], 2'b00});
        b = ACC_W'({pixel[4:0], 3'b000});

        // sums stay in 0..2^24, so modulo arithmetic gives the true value
        y_sum = Y_BIAS + r * Y_R + g * Y_G + b * Y_B;
        u_sum = C_BIAS + b * U_B - r * U_R - g * U_G;
        v_sum = C_BIAS + r * V_R - g * V_G - b * V_B;

        y = y_sum[23:16];
        u = u_sum[23:16];
        v = v_sum[23:16];
    end

endmodule
`default_nettype wire

// ----- tb/rgb565_to_nv12_converter_unit_test.sv -----
// Self-checking testbench for the RGB565 to NV12 converter unit.
`default_nettype none
module rgb565_to_nv12_converter_unit_test
    import rgbnv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int RANDOM_ITEMS = 720;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(15);

    typedef struct {
        logic [COL_W-1:0] luma;
        logic [OFS_W-1:0] luma_ofs;
        logic             chroma_valid;
        logic [COL_W-1:0] chroma_u;
        logic [COL_W-1:0] chroma_v;
        logic [OFS_W-1:0] chroma_ofs;
        logic             last;
        logic             stride_err;
    } nv12_px_t;

    class nv12_converter_model;
        logic [DIM_W-1:0]    width_reg  = RST_WIDTH;
        logic [DIM_W-1:0]    height_reg = RST_HEIGHT;
        logic [STRIDE_W-1:0] src_stride = RST_STRIDE;
        logic [STRIDE_W-1:0] dst_stride = RST_STRIDE;
        int unsigned         col_pos;
        int unsigned         row_pos;
        logic [OFS_W-1:0]    luma_base = '0;
        logic [OFS_W-1:0]    chroma_base = '0;
        nv12_px_t            pending_px[$];
        int                  fail_count;

        function int unsigned clamp_size(int unsigned v);
            if (v == 0)
                return 1;
            if (v > MAX_DIMENSION)
                return MAX_DIMENSION;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:   width_reg  = value[DIM_W-1:0];
                CFG_FRAME_HEIGHT:  height_reg = value[DIM_W-1:0];
                CFG_SOURCE_STRIDE: src_stride = value;
                CFG_LUMA_STRIDE:   dst_stride = value;
                default:           ;
            endcase
        endfunction

        function void accept_pixel(logic [PIX_W-1:0] p);
            nv12_px_t    e;
            longint      r, g, b, y, u, v;
            int unsigned w, h;
            logic        err, chroma, row_end, last;
            r = {p[15:11], 3'b000};
            g = {p[10:5], 2'b00};
            b = {p[4:0], 3'b000};
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);
            err = (w > src_stride) || (w > dst_stride);
            chroma = (row_pos % 2 == 0) && (col_pos % 2 == 0);
            row_end = (col_pos + 1) >= w;
            last = row_end && ((row_pos + 1) >= h);
            y = (16843 * r + 33030 * g + 6423 * b + (16 << 16)) >>> 16;
            u = ((128 << 16) + 28770 * b - 9699 * r - 19071 * g) >>> 16;
            v = ((128 << 16) + 28770 * r - 24117 * g - 4653 * b) >>> 16;
            e = '{default: '0};
            if (!err) begin
                e.luma = y[7:0];
                e.luma_ofs = luma_base + OFS_W'(col_pos);
                if (chroma) begin
                    e.chroma_valid = 1'b1;
                    e.chroma_u = u[7:0];
                    e.chroma_v = v[7:0];
                    e.chroma_ofs = chroma_base + OFS_W'(col_pos);
                end
            end
            e.last = last;
            e.stride_err = err;
            pending_px.push_back(e);
            if (last) begin
                col_pos = 0;
                row_pos = 0;
                luma_base = '0;
                chroma_base = '0;
            end else if (row_end) begin
                col_pos = 0;
                luma_base = luma_base + OFS_W'(dst_stride);
                if (row_pos % 2 == 0)
                    chroma_base = chroma_base + OFS_W'(dst_stride);
                row_pos++;
            end else begin
                col_pos++;
            end
        endfunction

        function void compare_field(string name, logic [OFS_W-1:0] want, logic [OFS_W-1:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_output(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] usr,
                                   logic lst);
            nv12_px_t e;
            if (pending_px.size() == 0) begin
                $display("%0t ns: result transfer with nothing expected, tdata 0x%0h",
                         $time, d);
                fail_count++;
                return;
            end
            e = pending_px.pop_front();
            compare_field("luma", e.luma, d[7:0]);
            compare_field("luma_offset", e.luma_ofs, d[32:8]);
            compare_field("chroma_u", e.chroma_u, d[40:33]);
            compare_field("chroma_v", e.chroma_v, d[48:41]);
            compare_field("chroma_offset", e.chroma_ofs, d[73:49]);
            compare_field("tdata pad", '0, d[79:74]);
            compare_field("chroma_valid", e.chroma_valid, usr[0]);
            compare_field("stride_error", e.stride_err, usr[1]);
            compare_field("last_of_frame", e.last, lst);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    nv12_converter_model model = new();
    bit                  quiet;
    int                  stall_left;
    int                  cycle_count;

    rgb565_to_nv12_converter_unit u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 65)
            return 0;
        if (k < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            model.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        do @(posedge clk); while (!s_axis_tready);
        model.accept_pixel(p);
    endtask

    task automatic send_random(input int n);
        logic [PIX_W-1:0] p;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0:       p = '0;
                1:       p = '1;
                default: p = PIX_W'($urandom_range(0, 65535));
            endcase
            send_pixel(p);
        end
    endtask

    // block idle: all results back plus pipeline latency
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (model.pending_px.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        model.set_reg(idx, CFG_DATA_W'(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, h, ss, ls);
        drain();
        cfg_write(CFG_FRAME_WIDTH, w);
        cfg_write(CFG_FRAME_HEIGHT, h);
        cfg_write(CFG_SOURCE_STRIDE, ss);
        cfg_write(CFG_LUMA_STRIDE, ls);
    endtask

    function automatic int unsigned pick_dim(input int unsigned lo_max, mid_max);
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return $urandom_range(1, lo_max);
        if (k < 90)
            return $urandom_range(lo_max + 1, mid_max);
        if (k < 95)
            return 0;
        return $urandom_range(MAX_DIMENSION + 1, 8191);
    endfunction

    function automatic int unsigned pick_stride(input int unsigned w);
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return $urandom_range(w, w + 50);
        if (k < 90)
            return $urandom_range(0, w - 1);
        return $urandom_range(0, 16383);
    endfunction

    initial
    begin
        int unsigned w, h, ss, ls;
        int          sent;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, then a 2x2 frame with color extremes
        send_pixel(16'h0000);
        drain();
        cfg_write(CFG_FRAME_WIDTH, 2);
        cfg_write(CFG_FRAME_HEIGHT, 2);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);

        // zero width and height act as one
        configure(0, 0, 16, 16);
        send_pixel(16'hFFFF);
        send_pixel(16'h8410);

        // zero luma stride, then source stride below width
        configure(3, 3, 3, 0);
        send_random(2);
        configure(3, 3, 2, 3);
        send_random(2);
        configure(3, 3, 0, 3);
        send_random(1);

        // spare indexes are ignored
        configure(3, 3, 3, 3);
        cfg_write(CFG_SPARE_LO, 1);
        cfg_write(CFG_SPARE_HI, 16383);
        send_random(3);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = pick_dim(8, 40);
            h = pick_dim(6, 20);
            ss = pick_stride(model.clamp_size(w));
            ls = pick_stride(model.clamp_size(w));
            drain();
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0: begin
                    cfg_write(CFG_FRAME_WIDTH, w);
                    cfg_write(CFG_LUMA_STRIDE, ls);
                end
                1: begin
                    cfg_write(CFG_FRAME_HEIGHT, h);
                    cfg_write(CFG_SPARE_LO, $urandom_range(0, 16383));
                end
                default: configure(w, h, ss, ls);
            endcase
            w = $urandom_range(30, 80);
            send_random(w);
            sent += w;
        end

        // oversize width register clamps, strides at MAX_STRIDE
        quiet = 1'b1;
        configure(1, 1, 1, 1);
        send_random(1);
        configure(8191, 1, 8192, 8192);
        send_random(32);

        // oversize height register, largest luma stride
        configure(1, 1, 1, 1);
        send_random(1);
        configure(1, 16383, 1, 16383);
        send_random(32);

        quiet = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (model.fail_count == 0 && model.pending_px.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
